### design/b64d_pkg.sv
// Package for the Base64 stream decoder: status codes, the burst record passed
// between the decode stage and the output serializer, and the character lookup.
// No dependencies.
package b64d_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_COUNT = 2'd1,
        STATUS_BAD_PAD   = 2'd2
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // One burst holds every result that a single character causes.
    typedef struct packed {
        logic [1:0]      nb;
        logic [2:0][7:0] data;
        logic            has_status;
        status_t         status;
        logic [15:0]     count;
    } burst_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.value = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]}) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]}) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B) begin
            s.value = 6'd62;
        end
        else if (c == 8'h2F) begin
            s.value = 6'd63;
        end
        else if (c == PAD_CHAR) begin
            s.value = 6'd0;
        end
        else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

### design/base64_stream_decoder_core.sv
// Top level of the Base64 stream decoder: decode stage followed by the output
// serializer. Depends on b64d_pkg, b64d_group and b64d_serial.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   input   | in_valid, in_ready | in_char, last_char
//   output  | out_valid, out_ready | out_byte, is_status, status, byte_count,
//           |                    | end_of_run
//
// One character is taken every cycle while the burst register is free or being
// emptied; a character causes zero to four result beats, one per cycle while
// out_ready is high. The serializer presents a burst's results one at a time;
// input stalls only when a burst waits. Reset clears the message state and both
// valid flags; no clearing pass is needed. A stalled output holds its beat; while
// a burst waits behind the last beat, in_ready follows out_ready in the same cycle.
module base64_stream_decoder_core #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_status,
    output logic [1:0]  status,
    output logic [15:0] byte_count,
    output logic        end_of_run
);

    logic             burst_valid;
    logic             burst_take;
    b64d_pkg::burst_t burst;

    b64d_group #(
        .COUNT_BITS (COUNT_BITS)
    ) u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .last_char   (last_char),
        .burst_valid (burst_valid),
        .burst_take  (burst_take),
        .burst       (burst)
    );

    b64d_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst_take  (burst_take),
        .burst       (burst),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_status   (is_status),
        .status      (status),
        .byte_count  (byte_count),
        .end_of_run  (end_of_run)
    );

`ifndef ASSERT_OFF
    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> end_of_run && out_byte == 8'd0)
        else $error("status beat must close its run");

    a_data_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> status == 2'd0 && byte_count == 16'd0)
        else $error("data beat carries status fields");

    a_last_makes_burst: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_char |=> burst_valid)
        else $error("last character produced no burst");

    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid && !burst_take |=> burst_valid && $stable(burst))
        else $error("pending burst changed before it was taken");
`endif

endmodule

### design/b64d_group.sv
// Decode stage: keeps the per-message state, folds one character per beat into
// the current group and registers the burst of results that the character causes.
// Depends on b64d_pkg.
module b64d_group #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_char,
    input  logic              last_char,
    output logic              burst_valid,
    input  logic              burst_take,
    output b64d_pkg::burst_t  burst
);

    logic [17:0]           hold_reg, hold_next;
    logic [1:0]            slot_reg, slot_next;
    logic [2:0]            pad_reg, pad_next;
    logic                  stopped_reg, stopped_next;
    logic [1:0]            vmf_reg, vmf_next;
    logic                  any_reg, any_next;
    logic                  pad_err_reg, pad_err_next;
    logic [COUNT_BITS-1:0] bytes_reg, bytes_next;
    logic                  bvalid_reg, bvalid_next;
    b64d_pkg::burst_t      burst_reg, burst_next;

    b64d_pkg::sextet_t     sx;
    logic                  accept;
    logic [2:0]            pad_inc;
    logic [23:0]           word;
    logic [1:0]            nb;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS+15:0] count_ext;

    assign in_ready = !bvalid_reg || burst_take;
    assign accept   = in_valid && in_ready;
    assign sx       = b64d_pkg::sextet_of(in_char);
    assign pad_inc  = (in_char == b64d_pkg::PAD_CHAR && pad_reg != 3'd7) ?
                      pad_reg + 3'd1 : pad_reg;
    assign word     = {hold_reg, sx.value};

    always_comb
    begin
        hold_next    = hold_reg;
        slot_next    = slot_reg;
        pad_next     = pad_reg;
        stopped_next = stopped_reg;
        vmf_next     = vmf_reg;
        any_next     = any_reg;
        pad_err_next = pad_err_reg;
        bytes_next   = bytes_reg;
        nb           = 2'd0;
        sum          = '0;
        if (sx.valid) begin
            vmf_next = vmf_reg + 2'd1;
            any_next = 1'b1;
            if (!stopped_reg) begin
                if (slot_reg != 2'd3) begin
                    hold_next = {hold_reg[11:0], sx.value};
                    slot_next = slot_reg + 2'd1;
                    pad_next  = pad_inc;
                end
                else begin
                    case (pad_inc)
                        3'd0:    nb = 2'd3;
                        3'd1:    nb = 2'd2;
                        3'd2:    nb = 2'd1;
                        default: pad_err_next = 1'b1;
                    endcase
                    sum = {1'b0, bytes_reg} + (COUNT_BITS+1)'(nb);
                    bytes_next   = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
                    stopped_next = (pad_inc != 3'd0);
                    hold_next    = '0;
                    slot_next    = 2'd0;
                    pad_next     = 3'd0;
                end
            end
        end
    end

    assign count_ext = (COUNT_BITS+16)'(bytes_next);

    always_comb
    begin
        burst_next.nb         = nb;
        burst_next.data[0]    = word[23:16];
        burst_next.data[1]    = word[15:8];
        burst_next.data[2]    = word[7:0];
        burst_next.has_status = last_char;
        burst_next.count      = count_ext[15:0];
        if (!any_next || vmf_next != 2'd0) begin
            burst_next.status = b64d_pkg::STATUS_BAD_COUNT;
        end
        else if (pad_err_next) begin
            burst_next.status = b64d_pkg::STATUS_BAD_PAD;
        end
        else begin
            burst_next.status = b64d_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        bvalid_next = bvalid_reg && !burst_take;
        if (accept && (nb != 2'd0 || last_char)) begin
            bvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_reg    <= '0;
            slot_reg    <= '0;
            pad_reg     <= '0;
            stopped_reg <= 1'b0;
            vmf_reg     <= '0;
            any_reg     <= 1'b0;
            pad_err_reg <= 1'b0;
            bytes_reg   <= '0;
            bvalid_reg  <= 1'b0;
        end
        else begin
            bvalid_reg <= bvalid_next;
            if (accept) begin
                if (last_char) begin
                    hold_reg    <= '0;
                    slot_reg    <= '0;
                    pad_reg     <= '0;
                    stopped_reg <= 1'b0;
                    vmf_reg     <= '0;
                    any_reg     <= 1'b0;
                    pad_err_reg <= 1'b0;
                    bytes_reg   <= '0;
                end
                else begin
                    hold_reg    <= hold_next;
                    slot_reg    <= slot_next;
                    pad_reg     <= pad_next;
                    stopped_reg <= stopped_next;
                    vmf_reg     <= vmf_next;
                    any_reg     <= any_next;
                    pad_err_reg <= pad_err_next;
                    bytes_reg   <= bytes_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            burst_reg <= burst_next;
        end
    end

    assign burst_valid = bvalid_reg;
    assign burst       = burst_reg;

endmodule

### design/b64d_serial.sv
// Output serializer: holds one burst and presents its results one beat at a time,
// data bytes first and the status item last.
// Depends on b64d_pkg.
module b64d_serial (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             burst_valid,
    output logic             burst_take,
    input  b64d_pkg::burst_t burst,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             is_status,
    output logic [1:0]       status,
    output logic [15:0]      byte_count,
    output logic             end_of_run
);

    b64d_pkg::burst_t cur_reg;
    logic             valid_reg, valid_next;
    logic [1:0]       pos_reg, pos_next;
    logic [2:0]       total;
    logic [1:0]       last_pos;
    logic             at_last;
    logic             at_data;
    logic             done;

    assign total    = {1'b0, cur_reg.nb} + {2'b00, cur_reg.has_status};
    assign last_pos = 2'(total - 3'd1);
    assign at_last  = (pos_reg == last_pos);
    assign at_data  = (pos_reg < cur_reg.nb);
    assign done     = valid_reg && out_ready && at_last;

    assign burst_take = burst_valid && (!valid_reg || done);

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        if (burst_take) begin
            valid_next = 1'b1;
            pos_next   = 2'd0;
        end
        else if (done) begin
            valid_next = 1'b0;
            pos_next   = 2'd0;
        end
        else if (valid_reg && out_ready) begin
            pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_take) begin
            cur_reg <= burst;
        end
    end

    always_comb
    begin
        out_byte   = 8'd0;
        is_status  = 1'b0;
        status     = b64d_pkg::STATUS_OK;
        byte_count = 16'd0;
        if (at_data) begin
            out_byte = cur_reg.data[pos_reg];
        end
        else begin
            is_status  = 1'b1;
            status     = cur_reg.status;
            byte_count = cur_reg.count;
        end
    end

    assign out_valid  = valid_reg;
    assign end_of_run = at_last;

endmodule

### tb/base64_stream_decoder_core_tb.sv
// Self-checking testbench for base64_stream_decoder_core: a directed table and random
// messages under several idle and stall mixes, checked beat by beat against a decoder model.
// Depends on b64d_pkg and the decoder RTL.
module base64_stream_decoder_core_tb;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [7:0]        data;
        logic              is_st;
        b64d_pkg::status_t st;
        logic [15:0]       cnt;
        logic              eor;
    } out_beat_t;

    typedef struct {
        logic [7:0]        c;
        logic              l;
        logic              chk;
        b64d_pkg::status_t st;
        logic [15:0]       cnt;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_char;
    logic        last_char;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        is_status;
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic        end_of_run;

    base64_stream_decoder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .is_status  (is_status),
        .status     (status),
        .byte_count (byte_count),
        .end_of_run (end_of_run)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Decoder state mirrored for prediction.
    logic [17:0] grp_bits;
    logic [1:0]  grp_slot;
    logic [2:0]  grp_pads;
    logic        halted;
    logic [1:0]  vmod4;
    logic        saw_valid;
    logic        pad_fault;
    logic [15:0] msg_bytes;

    out_beat_t decoded_beats_due[$];
    stim_row_t msg_chars[$];
    int        mismatches = 0;
    int        counted = 0;
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        cycles = 0;

    stim_row_t dir_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, b64d_pkg::STATUS_BAD_COUNT, 16'd0},
        '{"T",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"W",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"F",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"u",   1'b1, 1'b1, b64d_pkg::STATUS_OK,        16'd3},
        '{"/",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{8'hFF, 1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"+",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"9",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{8'h80, 1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"z",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"A",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"Z",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"a",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"0",   1'b1, 1'b1, b64d_pkg::STATUS_OK,        16'd6},
        '{"A",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"=",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"=",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"=",   1'b1, 1'b1, b64d_pkg::STATUS_BAD_PAD,   16'd0},
        '{"T",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"Q",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"=",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"=",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{"Q",   1'b0, 1'b0, b64d_pkg::STATUS_OK,        16'd0},
        '{" ",   1'b1, 1'b1, b64d_pkg::STATUS_BAD_COUNT, 16'd1}
    };

    function automatic int sextet_value(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (ALPHABET[8*(63-i) +: 8] == c)
            begin
                return i;
            end
        end
        if (c == b64d_pkg::PAD_CHAR)
        begin
            return 0;
        end
        return -1;
    endfunction

    function automatic logic [7:0] alpha_char();
        return ALPHABET[8*(63-$urandom_range(0, 63)) +: 8];
    endfunction

    function automatic logic [7:0] noise_char();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void clear_msg();
        grp_bits = '0;
        grp_slot = '0;
        grp_pads = '0;
        halted = 1'b0;
        vmod4 = '0;
        saw_valid = 1'b0;
        pad_fault = 1'b0;
        msg_bytes = '0;
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic l);
        int          v;
        int          nb;
        int          total;
        int          first;
        logic [23:0] word;
        out_beat_t   r;
        first = decoded_beats_due.size();
        v = sextet_value(c);
        if (v >= 0)
        begin
            vmod4 = vmod4 + 2'd1;
            saw_valid = 1'b1;
            if (!halted)
            begin
                if (c == b64d_pkg::PAD_CHAR && grp_pads < 3'd7)
                begin
                    grp_pads = grp_pads + 3'd1;
                end
                if (grp_slot < 2'd3)
                begin
                    grp_bits = {grp_bits[11:0], 6'(v)};
                    grp_slot = grp_slot + 2'd1;
                end
                else
                begin
                    word = {grp_bits, 6'(v)};
                    nb = (grp_pads > 3'd2) ? 0 : 3 - int'(grp_pads);
                    if (grp_pads > 3'd2)
                    begin
                        pad_fault = 1'b1;
                    end
                    for (int i = 0; i < nb; i++)
                    begin
                        r = '0;
                        r.data = word[23-8*i -: 8];
                        decoded_beats_due.push_back(r);
                    end
                    total = int'(msg_bytes) + nb;
                    msg_bytes = (total > 16'hFFFF) ? 16'hFFFF : 16'(total);
                    if (grp_pads != 3'd0)
                    begin
                        halted = 1'b1;
                    end
                    grp_bits = '0;
                    grp_slot = '0;
                    grp_pads = '0;
                end
            end
        end
        if (l)
        begin
            r = '0;
            r.is_st = 1'b1;
            if (!saw_valid || vmod4 != 2'd0)
            begin
                r.st = b64d_pkg::STATUS_BAD_COUNT;
            end
            else if (pad_fault)
            begin
                r.st = b64d_pkg::STATUS_BAD_PAD;
            end
            else
            begin
                r.st = b64d_pkg::STATUS_OK;
            end
            r.cnt = msg_bytes;
            decoded_beats_due.push_back(r);
            clear_msg();
        end
        if (decoded_beats_due.size() > first)
        begin
            decoded_beats_due[$].eor = 1'b1;
        end
    endfunction

    task automatic push_char(input logic [7:0] c, input logic l);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char <= c;
        last_char <= l;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        decode_char(c, l);
        counted++;
    endtask

    function automatic void add_char(input logic [7:0] c);
        stim_row_t row;
        row = '{c, 1'b0, 1'b0, b64d_pkg::STATUS_OK, 16'd0};
        msg_chars.push_back(row);
    endfunction

    // Mostly well-formed messages; some carry excess or stray padding, a missing or extra
    // character, or characters after a padded group; random noise bytes may be mixed in.
    function automatic void compose_message();
        int         kind;
        int         ngroups;
        int         pads;
        logic [7:0] g [4];
        msg_chars.delete();
        kind = $urandom_range(0, 99);
        ngroups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
        for (int k = 0; k < ngroups; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                g[j] = alpha_char();
            end
            pads = 0;
            if (k == ngroups - 1 && kind < 55)
            begin
                pads = $urandom_range(0, 2);
            end
            else if (k == ngroups - 1 && kind < 65)
            begin
                pads = $urandom_range(3, 4);
            end
            for (int j = 4 - pads; j < 4; j++)
            begin
                g[j] = b64d_pkg::PAD_CHAR;
            end
            for (int j = 0; j < 4; j++)
            begin
                if (kind >= 65 && kind < 75 && $urandom_range(0, 5) == 0)
                begin
                    g[j] = b64d_pkg::PAD_CHAR;
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    add_char(noise_char());
                end
                add_char(g[j]);
            end
        end
        if (kind >= 75 && kind < 87)
        begin
            if (msg_chars.size() > 0 && $urandom_range(0, 1) == 1)
            begin
                void'(msg_chars.pop_back());
            end
            else
            begin
                add_char(alpha_char());
            end
        end
        if (kind >= 87)
        begin
            for (int j = 0; j < 4; j++)
            begin
                add_char((j >= 2 + $urandom_range(0, 1)) ? b64d_pkg::PAD_CHAR : alpha_char());
            end
            repeat ($urandom_range(1, 6))
            begin
                add_char(($urandom_range(0, 3) == 0) ? b64d_pkg::PAD_CHAR : alpha_char());
            end
        end
        if (msg_chars.size() == 0 || $urandom_range(0, 7) == 0)
        begin
            add_char(noise_char());
        end
        msg_chars[$].l = 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic take_beat();
        out_beat_t want;
        if (decoded_beats_due.size() == 0)
        begin
            $error("unexpected beat: out_byte %0h is_status %0b status %0d byte_count %0d",
                   out_byte, is_status, status, byte_count);
            mismatches++;
        end
        else
        begin
            want = decoded_beats_due.pop_front();
            check_field("out_byte", 16'(want.data), 16'(out_byte));
            check_field("is_status", 16'(want.is_st), 16'(is_status));
            check_field("status", 16'(want.st), 16'(status));
            check_field("byte_count", want.cnt, byte_count);
            check_field("end_of_run", 16'(want.eor), 16'(end_of_run));
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                take_beat();
            end
            out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_char <= 8'h00;
        last_char <= 1'b0;
        clear_msg();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            push_char(dir_rows[i].c, dir_rows[i].l);
            if (dir_rows[i].chk)
            begin
                decoded_beats_due[$].st = dir_rows[i].st;
                decoded_beats_due[$].cnt = dir_rows[i].cnt;
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = (ph == 1) ? 88 : (ph == 3) ? 34 : 0;
            sink_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 34 : 0;
            while (counted < (ph + 1) * ITEMS_PER_PHASE)
            begin
                compose_message();
                while (msg_chars.size() > 0)
                begin
                    stim_row_t row;
                    row = msg_chars.pop_front();
                    push_char(row.c, row.l);
                end
            end
        end
        in_valid <= 1'b0;
        sink_stall_pct = 0;

        while (decoded_beats_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
